@@ rtl/csa_pkg.sv @@
package csa_pkg;

  localparam int SYM_CNT     = 4;
  localparam int SYM_W       = 2;
  localparam int WIN_SLOTS   = 15;
  localparam int PTR_W       = $clog2(WIN_SLOTS);
  localparam int SLOT_DEPTH  = WIN_SLOTS * SYM_CNT;
  localparam int SLOT_AW     = $clog2(SLOT_DEPTH);
  localparam int PRICE_W     = 48;
  localparam int VOL_IN_W    = 48;
  localparam int VOL_W       = 56;
  localparam int PSUM_W      = 64;
  localparam int CNT_W       = 32;
  localparam int WVOL_W      = 60;
  localparam int WN_W        = $clog2(WIN_SLOTS + 1);
  localparam int WSUM_W      = PRICE_W + WN_W;

  localparam logic CMD_TRADE = 1'b0;
  localparam logic CMD_TICK  = 1'b1;

  typedef struct packed {
    logic [PRICE_W-1:0] open_p;
    logic [PRICE_W-1:0] close_p;
    logic [PRICE_W-1:0] low_p;
    logic [PRICE_W-1:0] high_p;
    logic [VOL_W-1:0]   vol;
    logic [PSUM_W-1:0]  psum;
    logic [CNT_W-1:0]   cnt;
  } minute_t;

  typedef struct packed {
    logic [PRICE_W-1:0] mean;
    logic [VOL_W-1:0]   vol;
  } slot_t;

  typedef struct packed {
    logic              start;
    logic [PSUM_W-1:0] dividend;
    logic [CNT_W-1:0]  divisor;
  } div_req_t;

  typedef struct packed {
    logic              busy;
    logic              done;
    logic [PSUM_W-1:0] quotient;
  } div_rsp_t;

endpackage

@@ rtl/csa_if.sv @@
interface csa_in_if;
  import csa_pkg::*;
  logic                valid;
  logic                ready;
  logic                command;
  logic [SYM_W-1:0]    symbol_index;
  logic [PRICE_W-1:0]  trade_price;
  logic [VOL_IN_W-1:0] trade_volume;
  modport source (output valid, command, symbol_index, trade_price, trade_volume,
                  input ready);
  modport sink (input valid, command, symbol_index, trade_price, trade_volume,
                output ready);
endinterface

interface csa_out_if;
  import csa_pkg::*;
  logic               valid;
  logic               ready;
  logic [SYM_W-1:0]   candle_symbol;
  logic [PRICE_W-1:0] open_value;
  logic [PRICE_W-1:0] close_value;
  logic [PRICE_W-1:0] low_value;
  logic [PRICE_W-1:0] high_value;
  logic [VOL_W-1:0]   minute_volume;
  logic               window_valid;
  logic [PRICE_W-1:0] window_mean_price;
  logic [WVOL_W-1:0]  window_volume;
  logic               last_candle;
  modport source (output valid, candle_symbol, open_value, close_value, low_value,
                  high_value, minute_volume, window_valid, window_mean_price,
                  window_volume, last_candle, input ready);
  modport sink (input valid, candle_symbol, open_value, close_value, low_value,
                high_value, minute_volume, window_valid, window_mean_price,
                window_volume, last_candle, output ready);
endinterface

@@ rtl/per_symbol_candlestick_aggregator.sv @@
// Per-symbol one-minute candle builder. A trade word updates the open, close,
// low, high, volume, price sum and count of its symbol; these live in a small
// minute memory, and a trade is one read and one write back. A tick word
// closes the minute and produces one candle word per symbol in symbol order,
// the last flagged by last_candle. For each symbol the tick reads the minute
// entry, divides price sum by count in a shared 64-step divider, writes the
// minute average and volume into a 15-slot history memory, and once the
// history has filled sweeps all 15 slots one at a time and divides again for
// the window mean. The divider and the slot-by-slot history sweep set the
// length of a tick; a stalled output adds to it. Minute entries are cleared
// by per-symbol valid bits, not by writes. The history memory needs no
// clearing: it is only read once every slot has been written. Sums saturate;
// the average is clamped to 48 bits.
module per_symbol_candlestick_aggregator import csa_pkg::*; (
  input logic clk,
  input logic rst,
  csa_in_if.sink    trade_in,
  csa_out_if.source candle_out
);

  typedef enum logic [3:0] {
    IDLE, T_UPD, K_LOAD, K_DIVS, K_DIV1W, K_SLOT, K_SWRD, K_SWACC,
    K_DIV2S, K_DIV2W, K_EMIT
  } state_t;

  localparam logic [PRICE_W-1:0] PRICE_MAX = '1;
  localparam logic [WVOL_W-1:0]  WVOL_MAX  = '1;

  state_t state;

  // latched trade word
  logic [SYM_W-1:0]    sym_q;
  logic [PRICE_W-1:0]  price_q;
  logic [VOL_IN_W-1:0] vol_q;

  logic [SYM_CNT-1:0]  mvalid;   // minute entry holds trades
  logic [SYM_W-1:0]    sidx;
  logic [PTR_W-1:0]    ptr;
  logic                hfull;

  minute_t             cur;
  logic [PRICE_W-1:0]  avg;
  logic [PTR_W-1:0]    slot_i;
  logic [WSUM_W-1:0]   wsum;
  logic [WN_W-1:0]     wn;
  logic [WVOL_W-1:0]   wvol;
  logic [PRICE_W-1:0]  wmean;

  logic                ov;

  // memories
  logic                       m_re;
  logic [SYM_W-1:0]           m_raddr;
  logic [$bits(minute_t)-1:0] m_rdata;
  logic                       m_we;
  minute_t                    m_wdata;
  logic                       s_we;
  logic                       s_re;
  logic [SLOT_AW-1:0]         s_waddr;
  logic [SLOT_AW-1:0]         s_raddr;
  slot_t                      s_wdata;
  logic [$bits(slot_t)-1:0]   s_rdata;

  div_req_t div_req;
  div_rsp_t div_rsp;

  logic    in_acc;
  logic    emit;
  logic    last_sym;
  minute_t rd;
  minute_t base;
  slot_t   sd;

  logic [VOL_W:0]      vsum;
  logic [PSUM_W:0]     psum;
  logic [WVOL_W:0]     wvsum;

  assign in_acc   = trade_in.valid && trade_in.ready;
  assign emit     = (state == K_EMIT) && (!ov || candle_out.ready);
  assign last_sym = sidx == SYM_W'(SYM_CNT - 1);
  assign rd       = minute_t'(m_rdata);
  assign sd       = slot_t'(s_rdata);

  // reset view of an untouched minute entry for trade updates
  always_comb begin
    base = rd;
    if (!mvalid[sym_q]) begin
      base = '0;
      base.low_p = PRICE_MAX;
    end
  end

  assign vsum  = {1'b0, base.vol} + (VOL_W + 1)'(vol_q);
  assign psum  = {1'b0, base.psum} + (PSUM_W + 1)'(price_q);
  assign wvsum = {1'b0, wvol} + (WVOL_W + 1)'(sd.vol);

  always_comb begin
    m_wdata         = base;
    m_wdata.open_p  = mvalid[sym_q] ? base.open_p : price_q;
    m_wdata.close_p = price_q;
    m_wdata.low_p   = (price_q < base.low_p) ? price_q : base.low_p;
    m_wdata.high_p  = (price_q > base.high_p) ? price_q : base.high_p;
    m_wdata.vol     = vsum[VOL_W] ? '1 : vsum[VOL_W-1:0];
    m_wdata.psum    = psum[PSUM_W] ? '1 : psum[PSUM_W-1:0];
    m_wdata.cnt     = (&base.cnt) ? base.cnt : base.cnt + CNT_W'(1);
  end

  assign m_we    = state == T_UPD;
  assign m_re    = (state == IDLE && in_acc) || (emit && !last_sym);
  assign m_raddr = (state == IDLE) ?
                   ((trade_in.command == CMD_TICK) ? '0 : trade_in.symbol_index) :
                   sidx + SYM_W'(1);

  assign s_we         = state == K_SLOT;
  assign s_waddr      = SLOT_AW'(int'(ptr) * SYM_CNT + int'(sidx));
  assign s_wdata.mean = avg;
  assign s_wdata.vol  = cur.vol;
  assign s_re         = state == K_SWRD;
  assign s_raddr      = SLOT_AW'(int'(slot_i) * SYM_CNT + int'(sidx));

  always_comb begin
    div_req.start    = (state == K_DIVS && cur.cnt != '0) ||
                       (state == K_DIV2S && wn != '0);
    div_req.dividend = (state == K_DIVS) ? cur.psum : PSUM_W'(wsum);
    div_req.divisor  = (state == K_DIVS) ? cur.cnt : CNT_W'(wn);
  end

  csa_ram #(.W($bits(minute_t)), .D(SYM_CNT)) u_minute_ram (
    .clk(clk), .we(m_we), .waddr(sym_q), .wdata(m_wdata),
    .re(m_re), .raddr(m_raddr), .rdata(m_rdata)
  );

  csa_ram #(.W($bits(slot_t)), .D(SLOT_DEPTH)) u_slot_ram (
    .clk(clk), .we(s_we), .waddr(s_waddr), .wdata(s_wdata),
    .re(s_re), .raddr(s_raddr), .rdata(s_rdata)
  );

  csa_div u_div (.clk(clk), .rst(rst), .req(div_req), .rsp(div_rsp));

  assign trade_in.ready = state == IDLE;
  assign candle_out.valid = ov;

  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= IDLE;
      mvalid <= '0;
      sidx   <= '0;
      ptr    <= '0;
      hfull  <= 1'b0;
      ov     <= 1'b0;
    end else begin
      if (candle_out.ready && !emit) begin
        ov <= 1'b0;
      end
      case (state)
        IDLE: begin
          if (in_acc) begin
            sym_q   <= trade_in.symbol_index;
            price_q <= trade_in.trade_price;
            vol_q   <= trade_in.trade_volume;
            if (trade_in.command == CMD_TICK) begin
              sidx <= '0;
              if (ptr == PTR_W'(WIN_SLOTS - 1)) begin
                hfull <= 1'b1;
              end
              state <= K_LOAD;
            end else if (int'(trade_in.symbol_index) < SYM_CNT) begin
              state <= T_UPD;
            end
          end
        end
        T_UPD: begin
          mvalid[sym_q] <= 1'b1;
          state <= IDLE;
        end
        K_LOAD: begin
          cur   <= mvalid[sidx] ? rd : '0;
          state <= K_DIVS;
        end
        K_DIVS: begin
          if (cur.cnt == '0) begin
            avg   <= '0;
            state <= K_SLOT;
          end else begin
            state <= K_DIV1W;
          end
        end
        K_DIV1W: begin
          if (div_rsp.done) begin
            avg <= (|div_rsp.quotient[PSUM_W-1:PRICE_W]) ? PRICE_MAX :
                   div_rsp.quotient[PRICE_W-1:0];
            state <= K_SLOT;
          end
        end
        K_SLOT: begin
          slot_i <= '0;
          wsum   <= '0;
          wn     <= '0;
          wvol   <= '0;
          wmean  <= '0;
          state  <= hfull ? K_SWRD : K_EMIT;
        end
        K_SWRD: begin
          state <= K_SWACC;
        end
        K_SWACC: begin
          if (sd.mean != '0) begin
            wsum <= wsum + WSUM_W'(sd.mean);
            wn   <= wn + WN_W'(1);
          end
          wvol <= wvsum[WVOL_W] ? WVOL_MAX : wvsum[WVOL_W-1:0];
          if (slot_i == PTR_W'(WIN_SLOTS - 1)) begin
            state <= K_DIV2S;
          end else begin
            slot_i <= slot_i + PTR_W'(1);
            state  <= K_SWRD;
          end
        end
        K_DIV2S: begin
          state <= (wn == '0) ? K_EMIT : K_DIV2W;
        end
        K_DIV2W: begin
          if (div_rsp.done) begin
            wmean <= div_rsp.quotient[PRICE_W-1:0];
            state <= K_EMIT;
          end
        end
        K_EMIT: begin
          if (emit) begin
            ov <= 1'b1;
            candle_out.candle_symbol     <= sidx;
            candle_out.open_value        <= cur.open_p;
            candle_out.close_value       <= cur.close_p;
            candle_out.low_value         <= cur.low_p;
            candle_out.high_value        <= cur.high_p;
            candle_out.minute_volume     <= cur.vol;
            candle_out.window_valid      <= hfull;
            candle_out.window_mean_price <= wmean;
            candle_out.window_volume     <= wvol;
            candle_out.last_candle       <= last_sym;
            mvalid[sidx] <= 1'b0;
            if (last_sym) begin
              ptr   <= (ptr == PTR_W'(WIN_SLOTS - 1)) ? '0 : ptr + PTR_W'(1);
              state <= IDLE;
            end else begin
              sidx  <= sidx + SYM_W'(1);
              state <= K_LOAD;
            end
          end
        end
        default: state <= IDLE;
      endcase
    end
  end

  a_ptr_range: assert property (@(posedge clk) disable iff (rst)
    int'(ptr) < WIN_SLOTS) else $error("slot pointer out of range");
  a_trade_marks: assert property (@(posedge clk) disable iff (rst)
    state == T_UPD |=> mvalid[sym_q]) else $error("trade did not mark entry");
  a_last_sym: assert property (@(posedge clk) disable iff (rst)
    ov && candle_out.last_candle |-> candle_out.candle_symbol == SYM_W'(SYM_CNT - 1))
    else $error("last flag on wrong symbol");
  a_window_zero: assert property (@(posedge clk) disable iff (rst)
    ov && !candle_out.window_valid |->
      candle_out.window_volume == '0 && candle_out.window_mean_price == '0)
    else $error("window values before history filled");
  a_tick_clears: assert property (@(posedge clk) disable iff (rst)
    emit && last_sym |=> mvalid == '0) else $error("minute not cleared by tick");
endmodule

@@ rtl/csa_ram.sv @@
module csa_ram #(
  parameter int W = 8,
  parameter int D = 4
) (
  input  logic                 clk,
  input  logic                 we,
  input  logic [$clog2(D)-1:0] waddr,
  input  logic [W-1:0]         wdata,
  input  logic                 re,
  input  logic [$clog2(D)-1:0] raddr,
  output logic [W-1:0]         rdata
);
  logic [W-1:0] mem [D];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end
endmodule

@@ rtl/csa_div.sv @@
// Restoring divider, one quotient bit per cycle.
module csa_div import csa_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  input  div_req_t req,
  output div_rsp_t rsp
);
  localparam int STEP_W = $clog2(PSUM_W + 1);

  logic [PSUM_W-1:0] q;
  logic [CNT_W-1:0]  d;
  logic [CNT_W-1:0]  rem;
  logic [STEP_W-1:0] steps;
  logic              busy;
  logic              done;
  logic [CNT_W:0]    trial;
  logic              fits;

  assign trial = {rem, q[PSUM_W-1]};
  assign fits  = trial >= {1'b0, d};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy  <= 1'b0;
      done  <= 1'b0;
      steps <= '0;
    end else begin
      done <= 1'b0;
      if (req.start && !busy) begin
        busy  <= 1'b1;
        q     <= req.dividend;
        d     <= req.divisor;
        rem   <= '0;
        steps <= STEP_W'(PSUM_W);
      end else if (busy) begin
        rem   <= fits ? CNT_W'(trial - {1'b0, d}) : trial[CNT_W-1:0];
        q     <= {q[PSUM_W-2:0], fits};
        steps <= steps - STEP_W'(1);
        if (steps == STEP_W'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  assign rsp.busy     = busy;
  assign rsp.done     = done;
  assign rsp.quotient = q;

  a_no_start_busy: assert property (@(posedge clk) disable iff (rst)
    req.start |-> !busy) else $error("divider started while busy");
  a_done_after_busy: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(busy)) else $error("divider done without work");
  a_zero_divisor: assert property (@(posedge clk) disable iff (rst)
    req.start |-> req.divisor != '0) else $error("divide by zero");
endmodule

@@ verif/per_symbol_candlestick_aggregator_tb.sv @@
module per_symbol_candlestick_aggregator_tb;
  import csa_pkg::*;

  // Saturation values (all ones) of the price, volume, price sum, count and window volume fields.
  localparam logic [PRICE_W-1:0] PRICE_MAX = {PRICE_W{1'b1}};
  localparam logic [VOL_W-1:0]   VOL_MAX   = {VOL_W{1'b1}};
  localparam logic [PSUM_W-1:0]  PSUM_MAX  = {PSUM_W{1'b1}};
  localparam logic [CNT_W-1:0]   CNT_MAX   = {CNT_W{1'b1}};
  localparam logic [WVOL_W-1:0]  WVOL_MAX  = {WVOL_W{1'b1}};
  // No word accepted on either side for this many cycles means the block has hung.
  localparam int WATCHDOG_LIMIT = 20000;
  localparam int N_RANDOM       = 230;

  typedef struct packed {
    logic               command;
    logic [SYM_W-1:0]   symbol_index;
    logic [PRICE_W-1:0] trade_price;
    logic [VOL_IN_W-1:0] trade_volume;
  } trade_word_t;

  typedef struct packed {
    logic [SYM_W-1:0]   candle_symbol;
    logic [PRICE_W-1:0] open_value;
    logic [PRICE_W-1:0] close_value;
    logic [PRICE_W-1:0] low_value;
    logic [PRICE_W-1:0] high_value;
    logic [VOL_W-1:0]   minute_volume;
    logic               window_valid;
    logic [PRICE_W-1:0] window_mean_price;
    logic [WVOL_W-1:0]  window_volume;
    logic               last_candle;
  } candle_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  csa_in_if  trade_bus ();
  csa_out_if candle_bus ();

  per_symbol_candlestick_aggregator uut (
    .clk        (clk),
    .rst        (rst),
    .trade_in   (trade_bus.sink),
    .candle_out (candle_bus.source)
  );

  always #5 clk = ~clk;

  // ---------------------------------------------------------------------
  // Shadow copy of the aggregator state: the open minute per symbol and
  // the ring of per-minute averages and volumes.
  // ---------------------------------------------------------------------
  logic [PRICE_W-1:0] sh_open  [SYM_CNT];
  logic [PRICE_W-1:0] sh_close [SYM_CNT];
  logic [PRICE_W-1:0] sh_low   [SYM_CNT];
  logic [PRICE_W-1:0] sh_high  [SYM_CNT];
  logic [VOL_W-1:0]   sh_vol   [SYM_CNT];
  logic [PSUM_W-1:0]  sh_psum  [SYM_CNT];
  logic [CNT_W-1:0]   sh_cnt   [SYM_CNT];
  logic               sh_seen  [SYM_CNT];
  logic [PRICE_W-1:0] ring_avg [WIN_SLOTS][SYM_CNT];
  logic [VOL_W-1:0]   ring_vol [WIN_SLOTS][SYM_CNT];
  int                 ring_ptr;
  logic               ring_full;

  trade_word_t pending_words[$];
  candle_t     expected_candles[$];
  int          fail_count = 0;
  int          quiet_cycles = 0;
  bit          drain_req = 1'b0;   // sender holds off until candles drain

  function automatic void open_minute(int s);
    sh_open[s]  = '0;
    sh_close[s] = '0;
    sh_low[s]   = PRICE_MAX;
    sh_high[s]  = '0;
    sh_vol[s]   = '0;
    sh_psum[s]  = '0;
    sh_cnt[s]   = '0;
    sh_seen[s]  = 1'b0;
  endfunction

  // Applies one accepted word to the shadow state; ticks queue four candles.
  function automatic void aggregate_word(trade_word_t w);
    int s;
    logic [PSUM_W:0] wide;
    logic [PSUM_W-1:0] avg;
    logic [WSUM_W-1:0] msum;
    logic [WVOL_W:0] wv;
    int n;
    candle_t c;
    s = w.symbol_index;
    if (w.command == CMD_TRADE) begin
      if (s >= SYM_CNT) return;
      if (!sh_seen[s]) begin
        sh_open[s] = w.trade_price;
        sh_seen[s] = 1'b1;
      end
      sh_close[s] = w.trade_price;
      if (w.trade_price < sh_low[s]) sh_low[s] = w.trade_price;
      if (w.trade_price > sh_high[s]) sh_high[s] = w.trade_price;
      wide = sh_vol[s] + w.trade_volume;
      sh_vol[s] = (wide > VOL_MAX) ? VOL_MAX : wide[VOL_W-1:0];
      wide = sh_psum[s] + w.trade_price;
      sh_psum[s] = wide[PSUM_W] ? PSUM_MAX : wide[PSUM_W-1:0];
      if (sh_cnt[s] != CNT_MAX) sh_cnt[s]++;
      return;
    end
    if (ring_ptr == WIN_SLOTS - 1) ring_full = 1'b1;
    for (int k = 0; k < SYM_CNT; k++) begin
      avg = '0;
      if (sh_cnt[k] != 0) begin
        avg = sh_psum[k] / sh_cnt[k];
        if (avg > PRICE_MAX) avg = PRICE_MAX;
      end
      ring_avg[ring_ptr][k] = avg[PRICE_W-1:0];
      ring_vol[ring_ptr][k] = sh_vol[k];
      c = '0;
      if (ring_full) begin
        msum = '0;
        n = 0;
        wv = '0;
        for (int i = 0; i < WIN_SLOTS; i++) begin
          if (ring_avg[i][k] != 0) begin
            msum += ring_avg[i][k];
            n++;
          end
          wv = wv + ring_vol[i][k];
          if (wv > WVOL_MAX) wv = WVOL_MAX;
        end
        if (n != 0) c.window_mean_price = PRICE_W'(msum / WSUM_W'(n));
        c.window_volume = wv[WVOL_W-1:0];
      end
      c.candle_symbol = SYM_W'(k);
      c.open_value    = sh_open[k];
      c.close_value   = sh_close[k];
      c.low_value     = sh_seen[k] ? sh_low[k] : '0;
      c.high_value    = sh_high[k];
      c.minute_volume = sh_vol[k];
      c.window_valid  = ring_full;
      c.last_candle   = (k == SYM_CNT - 1);
      expected_candles.push_back(c);
      open_minute(k);
    end
    ring_ptr = (ring_ptr == WIN_SLOTS - 1) ? 0 : ring_ptr + 1;
  endfunction

  // Mostly short gaps, now and then a long one.
  function automatic int gap_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  function automatic logic [PRICE_W-1:0] rand_price();
    case ($urandom_range(0, 5))
      0: return '0;
      1: return PRICE_MAX;
      2: return PRICE_W'({$urandom, $urandom});
      default: return {$urandom_range(1, 5000), 16'($urandom)};
    endcase
  endfunction

  function automatic void add_trade(int s, logic [PRICE_W-1:0] p,
                                    logic [VOL_IN_W-1:0] v);
    trade_word_t w;
    w.command      = CMD_TRADE;
    w.symbol_index = SYM_W'(s);
    w.trade_price  = p;
    w.trade_volume = v;
    pending_words.push_back(w);
  endfunction

  function automatic void add_tick();
    trade_word_t w;
    w = {CMD_TICK, SYM_W'($urandom), PRICE_W'({$urandom, $urandom}),
         VOL_IN_W'({$urandom, $urandom})};
    pending_words.push_back(w);
  endfunction

  // ---------------------------------------------------------------------
  // Driver: offers queued words with random gaps between them.
  // ---------------------------------------------------------------------
  int send_gap = 0;

  always @(posedge clk) begin
    if (rst) begin
      trade_bus.valid        <= 1'b0;
      trade_bus.command      <= CMD_TRADE;
      trade_bus.symbol_index <= '0;
      trade_bus.trade_price  <= '0;
      trade_bus.trade_volume <= '0;
    end else begin
      if (trade_bus.valid && trade_bus.ready) begin
        aggregate_word({trade_bus.command, trade_bus.symbol_index,
                        trade_bus.trade_price, trade_bus.trade_volume});
        void'(pending_words.pop_front());
        send_gap = gap_len();
      end
      if (trade_bus.valid && !trade_bus.ready) begin
        // keep offering the same word
      end else if (send_gap > 0) begin
        send_gap--;
        trade_bus.valid <= 1'b0;
      end else if (pending_words.size() != 0 &&
                   !(drain_req && expected_candles.size() != 0)) begin
        trade_bus.valid        <= 1'b1;
        trade_bus.command      <= pending_words[0].command;
        trade_bus.symbol_index <= pending_words[0].symbol_index;
        trade_bus.trade_price  <= pending_words[0].trade_price;
        trade_bus.trade_volume <= pending_words[0].trade_volume;
      end else begin
        trade_bus.valid <= 1'b0;
      end
    end
  end

  // ---------------------------------------------------------------------
  // Monitor: random back-pressure, checks every candle against the queue.
  // ---------------------------------------------------------------------
  int stall_left = 0;

  always @(posedge clk) begin
    candle_t got, want;
    if (rst) begin
      candle_bus.ready <= 1'b0;
    end else begin
      if (candle_bus.valid && candle_bus.ready) begin
        got = {candle_bus.candle_symbol, candle_bus.open_value,
               candle_bus.close_value, candle_bus.low_value,
               candle_bus.high_value, candle_bus.minute_volume,
               candle_bus.window_valid, candle_bus.window_mean_price,
               candle_bus.window_volume, candle_bus.last_candle};
        if (expected_candles.size() == 0) begin
          $error("unexpected candle word for symbol %0d", got.candle_symbol);
          fail_count++;
        end else begin
          want = expected_candles.pop_front();
          if (got.candle_symbol !== want.candle_symbol) begin
            $error("candle_symbol: expected %0d, got %0d",
                   want.candle_symbol, got.candle_symbol);
            fail_count++;
          end
          if (got.open_value !== want.open_value) begin
            $error("open_value: expected %0h, got %0h",
                   want.open_value, got.open_value);
            fail_count++;
          end
          if (got.close_value !== want.close_value) begin
            $error("close_value: expected %0h, got %0h",
                   want.close_value, got.close_value);
            fail_count++;
          end
          if (got.low_value !== want.low_value) begin
            $error("low_value: expected %0h, got %0h", want.low_value, got.low_value);
            fail_count++;
          end
          if (got.high_value !== want.high_value) begin
            $error("high_value: expected %0h, got %0h",
                   want.high_value, got.high_value);
            fail_count++;
          end
          if (got.minute_volume !== want.minute_volume) begin
            $error("minute_volume: expected %0h, got %0h",
                   want.minute_volume, got.minute_volume);
            fail_count++;
          end
          if (got.window_valid !== want.window_valid) begin
            $error("window_valid: expected %0d, got %0d",
                   want.window_valid, got.window_valid);
            fail_count++;
          end
          if (got.window_mean_price !== want.window_mean_price) begin
            $error("window_mean_price: expected %0h, got %0h",
                   want.window_mean_price, got.window_mean_price);
            fail_count++;
          end
          if (got.window_volume !== want.window_volume) begin
            $error("window_volume: expected %0h, got %0h",
                   want.window_volume, got.window_volume);
            fail_count++;
          end
          if (got.last_candle !== want.last_candle) begin
            $error("last_candle: expected %0d, got %0d",
                   want.last_candle, got.last_candle);
            fail_count++;
          end
        end
      end
      if (stall_left > 0) begin
        stall_left--;
        candle_bus.ready <= 1'b0;
      end else begin
        stall_left = gap_len();
        candle_bus.ready <= (stall_left == 0);
      end
    end
  end

  // Watchdog: counts cycles without any accepted word on either side.
  always @(posedge clk) begin
    if (rst || (trade_bus.valid && trade_bus.ready) ||
        (candle_bus.valid && candle_bus.ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("Some tests failed");
        $finish;
      end
    end
  end

  // ---------------------------------------------------------------------
  // Stimulus
  // ---------------------------------------------------------------------
  initial begin
    int r, minute_len;
    for (int s = 0; s < SYM_CNT; s++) open_minute(s);
    ring_ptr  = 0;
    ring_full = 1'b0;

    // Directed: empty minute for all, zero-price first trade, field extremes,
    // large volumes, then a minute where only some symbols trade.
    add_tick();
    add_trade(0, '0, '0);
    add_trade(0, PRICE_MAX, {VOL_IN_W{1'b1}});
    add_trade(0, 48'h1_0000, 48'h8000);
    add_trade(1, PRICE_MAX, {VOL_IN_W{1'b1}});
    for (int i = 0; i < 300; i++) begin
      if (i < 10) add_trade(2, PRICE_MAX - i, {VOL_IN_W{1'b1}});
    end
    add_trade(3, 48'h5555_5555_5555, 48'hAAAA_AAAA_AAAA);
    add_trade(3, 48'hAAAA_AAAA_AAAA, 48'h5555_5555_5555);
    add_tick();
    add_trade(2, 48'h20_0000, 48'h1_0000);
    add_tick();

    // Random minutes: mostly trades with small prices, a tick closing each.
    // Enough ticks to wrap the window ring at least once.
    for (int i = 0; i < N_RANDOM; i += minute_len + 1) begin
      minute_len = $urandom_range(0, 8);
      for (int k = 0; k < minute_len; k++) begin
        r = $urandom_range(0, 9);
        add_trade($urandom_range(0, SYM_CNT - 1), rand_price(),
                  (r == 0) ? {VOL_IN_W{1'b1}} : VOL_IN_W'({$urandom, $urandom}));
      end
      add_tick();
    end

    repeat (6) @(posedge clk);
    rst <= 1'b0;

    // Hold the sender once mid-run until every candle has come back.
    wait (pending_words.size() < N_RANDOM / 2);
    drain_req = 1'b1;
    wait (expected_candles.size() == 0);
    @(posedge clk);
    drain_req = 1'b0;

    wait (pending_words.size() == 0 && expected_candles.size() == 0);
    repeat (50) @(posedge clk);
    if (fail_count == 0 && expected_candles.size() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

@@ filelist.f @@
rtl/csa_pkg.sv
rtl/csa_if.sv
rtl/csa_ram.sv
rtl/csa_div.sv
rtl/per_symbol_candlestick_aggregator.sv
verif/per_symbol_candlestick_aggregator_tb.sv
